// File: hdl/evc_pkg.sv
// Shared types, constants and arithmetic helpers of the Euler XYZ view matrix core.
package evc_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 14;

  // Width of a Q1.F trig or rotation value, and of a product of two of them.
  localparam int TW = TRIG_FRAC_BITS + 2;
  localparam int PW = 2 * TW;
  // Width of the exact sum of three rotation by position products.
  localparam int SW = TW + 34;

  localparam int NLANE = 6;
  localparam int NCELL = 6;
  localparam int NSTG  = 8;
  localparam int EVC_DEPTH = 2 * NCELL + NSTG;

  localparam int L_S1 = 0;
  localparam int L_C1 = 1;
  localparam int L_S2 = 2;
  localparam int L_C2 = 3;
  localparam int L_S3 = 4;
  localparam int L_C3 = 5;

  localparam int ONE_I = 1 << TRIG_FRAC_BITS;
  localparam int RND_SH = 30 - TRIG_FRAC_BITS;

  localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
  localparam logic signed [31:0] POLY_A1 = 32'sd1686629713;
  localparam logic signed [31:0] POLY_A3 = -32'sd693598668;
  localparam logic signed [31:0] POLY_A5 = 32'sd85569310;
  localparam logic signed [31:0] POLY_A7 = -32'sd5026991;
  localparam logic signed [31:0] POLY_A9 = 32'sd172272;

  // Per cell setup of the polynomial chain: square, four Horner steps, final product.
  localparam logic [NCELL-1:0] CELL_USE_X   = 6'b100001;
  localparam logic [NCELL-1:0] CELL_LOAD_X2 = 6'b000001;
  localparam logic [NCELL-1:0] CELL_SEED_EN = 6'b000010;
  localparam logic signed [31:0] CELL_ADD [NCELL] =
    '{32'sd0, POLY_A7, POLY_A5, POLY_A3, POLY_A1, 32'sd0};

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
  } evc_in_t;

  typedef struct packed {
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic signed [15:0] wx;
    logic signed [15:0] wy;
    logic signed [15:0] wz;
    logic signed [31:0] trans_u;
    logic signed [31:0] trans_v;
    logic signed [31:0] trans_w;
  } evc_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] x2;
    logic signed [31:0] p;
    logic [1:0]         quad;
  } evc_lane_t;

  typedef struct packed {
    evc_lane_t [NLANE-1:0] lane;
    logic signed [31:0]    px;
    logic signed [31:0]    py;
    logic signed [31:0]    pz;
  } evc_trig_t;

  function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] r;
    mag = v[63] ? 64'(-v) : 64'(v);
    r = (mag + (64'd1 << 29)) >> 30;
    return v[63] ? -$signed(r[31:0]) : $signed(r[31:0]);
  endfunction

  function automatic logic signed [TW-1:0] clamp_tw(input logic signed [TW:0] v);
    logic signed [TW:0] t;
    t = v;
    if (v > (TW+1)'(ONE_I)) begin
      t = (TW+1)'(ONE_I);
    end else if (v < (TW+1)'(-ONE_I)) begin
      t = (TW+1)'(-ONE_I);
    end
    return t[TW-1:0];
  endfunction

  function automatic logic signed [TW-1:0] trig_out(input logic signed [31:0] s,
                                                     input logic [1:0] quad);
    logic [31:0] mag;
    logic [31:0] r;
    logic signed [31:0] t;
    logic signed [TW-1:0] c;
    mag = s[31] ? 32'(-s) : 32'(s);
    r = (mag + (32'd1 << (RND_SH - 1))) >> RND_SH;
    t = s[31] ? -$signed(r) : $signed(r);
    if (t > 32'(ONE_I)) begin
      t = 32'(ONE_I);
    end else if (t < 32'(-ONE_I)) begin
      t = 32'(-ONE_I);
    end
    c = t[TW-1:0];
    return quad[1] ? -c : c;
  endfunction

  function automatic logic signed [TW-1:0] rnd_pw(input logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    logic signed [TW-1:0] t;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    r = (mag + (PW'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
    t = r[TW-1:0];
    return v[PW-1] ? -t : t;
  endfunction

  function automatic logic signed [31:0] trans_out(input logic signed [SW-1:0] sum);
    logic          neg_res;
    logic [SW-1:0] mag;
    logic [SW-1:0] r;
    logic signed [31:0] t;
    neg_res = !sum[SW-1] && (sum != '0);
    mag = sum[SW-1] ? SW'(-sum) : SW'(sum);
    r = (mag + (SW'(1) << (TRIG_FRAC_BITS - 1))) >> TRIG_FRAC_BITS;
    if (neg_res) begin
      if (r > SW'(64'h80000000)) begin
        t = 32'sh80000000;
      end else begin
        t = -$signed(r[31:0]);
      end
    end else begin
      if (r > SW'(64'h7FFFFFFF)) begin
        t = 32'sh7FFFFFFF;
      end else begin
        t = $signed(r[31:0]);
      end
    end
    return t;
  endfunction

endpackage

// File: hdl/evc_trig_cell.sv
// One cell of the sine polynomial chain: a Q30 multiply, then round and add on all lanes.
module evc_trig_cell
  import evc_pkg::*;
#(
  parameter bit                 USE_X   = 1'b0,
  parameter bit                 LOAD_X2 = 1'b0,
  parameter bit                 SEED_EN = 1'b0,
  parameter logic signed [31:0] SEED    = POLY_A9,
  parameter logic signed [31:0] ADDEND  = 32'sd0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  evc_trig_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output evc_trig_t out_data_o
);

  logic               a_valid_q, b_valid_q;
  logic               a_en, b_en;
  evc_trig_t          a_data_q, b_data_q, b_data_d;
  logic signed [31:0] mul_a [NLANE];
  logic signed [31:0] mul_b [NLANE];
  logic signed [63:0] prod_d [NLANE];
  logic signed [63:0] prod_q [NLANE];
  logic signed [31:0] sum_d [NLANE];

  assign b_en = !b_valid_q || out_ready_i;
  assign a_en = !a_valid_q || b_en;
  assign in_ready_o = a_en;
  assign out_valid_o = b_valid_q;
  assign out_data_o = b_data_q;

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      mul_a[l] = SEED_EN ? SEED : in_data_i.lane[l].p;
      mul_b[l] = USE_X ? in_data_i.lane[l].x : in_data_i.lane[l].x2;
      prod_d[l] = mul_a[l] * mul_b[l];
    end
  end

  always_comb begin
    b_data_d = a_data_q;
    for (int l = 0; l < NLANE; l++) begin
      sum_d[l] = rnd_q30(prod_q[l]) + ADDEND;
      b_data_d.lane[l].p = sum_d[l];
      if (LOAD_X2) begin
        b_data_d.lane[l].x2 = sum_d[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_valid_q <= in_valid_i;
      end
      if (b_en) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_data_q <= in_data_i;
      prod_q   <= prod_d;
    end
    if (b_en) begin
      b_data_q <= b_data_d;
    end
  end

endmodule

// File: hdl/evc_basis.sv
// Rotation basis and translation stages that follow the sine chain.
module evc_basis
  import evc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  evc_trig_t in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output evc_out_t  out_o
);

  logic [NSTG-1:0]       v_q;
  logic [NSTG-1:0]       en;
  logic signed [TW-1:0]  tr_q [4][NLANE];
  logic signed [31:0]    pos_q [5][3];
  logic signed [PW-1:0]  pp_q [10];
  logic signed [TW-1:0]  pr_q [2][10];
  logic signed [PW-1:0]  tp_q [4];
  logic signed [TW-1:0]  m_d [9];
  logic signed [TW-1:0]  m_q [3][9];
  logic signed [TW+31:0] mp_q [9];
  logic signed [SW-1:0]  sum_q [3];
  evc_out_t              out_q;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];
  assign out_valid_o = v_q[NSTG-1];
  assign out_o = out_q;

  always_comb begin
    m_d[0] = clamp_tw((TW+1)'(pr_q[1][0]));
    m_d[1] = clamp_tw((TW+1)'(pr_q[1][1]) + (TW+1)'(rnd_pw(tp_q[0])));
    m_d[2] = clamp_tw((TW+1)'(pr_q[1][3]) - (TW+1)'(rnd_pw(tp_q[1])));
    m_d[3] = clamp_tw(-(TW+1)'(pr_q[1][5]));
    m_d[4] = clamp_tw((TW+1)'(pr_q[1][4]) - (TW+1)'(rnd_pw(tp_q[2])));
    m_d[5] = clamp_tw((TW+1)'(pr_q[1][2]) + (TW+1)'(rnd_pw(tp_q[3])));
    m_d[6] = clamp_tw((TW+1)'(tr_q[3][L_S2]));
    m_d[7] = clamp_tw(-(TW+1)'(pr_q[1][8]));
    m_d[8] = clamp_tw((TW+1)'(pr_q[1][9]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int l = 0; l < NLANE; l++) begin
        tr_q[0][l] <= trig_out(in_data_i.lane[l].p, in_data_i.lane[l].quad);
      end
      pos_q[0][0] <= in_data_i.px;
      pos_q[0][1] <= in_data_i.py;
      pos_q[0][2] <= in_data_i.pz;
    end
    if (en[1]) begin
      pp_q[0] <= tr_q[0][L_C2] * tr_q[0][L_C3];
      pp_q[1] <= tr_q[0][L_C1] * tr_q[0][L_S3];
      pp_q[2] <= tr_q[0][L_C3] * tr_q[0][L_S1];
      pp_q[3] <= tr_q[0][L_S1] * tr_q[0][L_S3];
      pp_q[4] <= tr_q[0][L_C1] * tr_q[0][L_C3];
      pp_q[5] <= tr_q[0][L_C2] * tr_q[0][L_S3];
      pp_q[6] <= tr_q[0][L_S1] * tr_q[0][L_S2];
      pp_q[7] <= tr_q[0][L_C1] * tr_q[0][L_S2];
      pp_q[8] <= tr_q[0][L_C2] * tr_q[0][L_S1];
      pp_q[9] <= tr_q[0][L_C1] * tr_q[0][L_C2];
      tr_q[1] <= tr_q[0];
      pos_q[1] <= pos_q[0];
    end
    if (en[2]) begin
      for (int i = 0; i < 10; i++) begin
        pr_q[0][i] <= rnd_pw(pp_q[i]);
      end
      tr_q[2] <= tr_q[1];
      pos_q[2] <= pos_q[1];
    end
    if (en[3]) begin
      tp_q[0] <= pr_q[0][2] * tr_q[2][L_S2];
      tp_q[1] <= pr_q[0][4] * tr_q[2][L_S2];
      tp_q[2] <= pr_q[0][6] * tr_q[2][L_S3];
      tp_q[3] <= pr_q[0][7] * tr_q[2][L_S3];
      pr_q[1] <= pr_q[0];
      tr_q[3] <= tr_q[2];
      pos_q[3] <= pos_q[2];
    end
    if (en[4]) begin
      m_q[0] <= m_d;
      pos_q[4] <= pos_q[3];
    end
    if (en[5]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mp_q[3*i+j] <= m_q[0][3*i+j] * pos_q[4][j];
        end
      end
      m_q[1] <= m_q[0];
    end
    if (en[6]) begin
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= SW'(mp_q[3*i]) + SW'(mp_q[3*i+1]) + SW'(mp_q[3*i+2]);
      end
      m_q[2] <= m_q[1];
    end
    if (en[7]) begin
      out_q.ux <= 16'(m_q[2][0]);
      out_q.uy <= 16'(m_q[2][1]);
      out_q.uz <= 16'(m_q[2][2]);
      out_q.vx <= 16'(m_q[2][3]);
      out_q.vy <= 16'(m_q[2][4]);
      out_q.vz <= 16'(m_q[2][5]);
      out_q.wx <= 16'(m_q[2][6]);
      out_q.wy <= 16'(m_q[2][7]);
      out_q.wz <= 16'(m_q[2][8]);
      out_q.trans_u <= trans_out(sum_q[0]);
      out_q.trans_v <= trans_out(sum_q[1]);
      out_q.trans_w <= trans_out(sum_q[2]);
    end
  end

endmodule

// File: hdl/euler_xyz_view_matrix_core.sv
// Top level of the Euler XYZ view matrix core.
// Takes one camera pose per cycle while the output is not stalled and returns its view
// matrix through the sine chain, six multiply cells of two registers each, followed
// by eight stages that build the basis and the translation.
// A stalled output holds the pipeline only as far back as its bubbles allow.
module euler_xyz_view_matrix_core
  import evc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  evc_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output evc_out_t out_o
);

  logic [31:0]        phase [3];
  logic [1:0]         lane_quad [NLANE];
  logic signed [31:0] lane_xr [NLANE];
  evc_trig_t          head_data;
  evc_trig_t          chain_data  [NCELL+1];
  logic               chain_valid [NCELL+1];
  logic               chain_ready [NCELL+1];

  assign phase[0] = 32'(in_i.angle_x) << (32 - ANGLE_BITS);
  assign phase[1] = 32'(in_i.angle_y) << (32 - ANGLE_BITS);
  assign phase[2] = 32'(in_i.angle_z) << (32 - ANGLE_BITS);

  always_comb begin
    head_data.px = in_i.pos_x;
    head_data.py = in_i.pos_y;
    head_data.pz = in_i.pos_z;
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 2; c++) begin
        lane_quad[2*a+c] = phase[a][31:30] + 2'(c);
        lane_xr[2*a+c] = {2'b00, phase[a][29:0]};
      end
    end
    for (int l = 0; l < NLANE; l++) begin
      head_data.lane[l].quad = lane_quad[l];
      head_data.lane[l].x = lane_quad[l][0] ? Q30_ONE - lane_xr[l] : lane_xr[l];
      head_data.lane[l].p = head_data.lane[l].x;
      head_data.lane[l].x2 = '0;
    end
  end

  assign chain_data[0] = head_data;
  assign chain_valid[0] = in_valid_i;
  assign in_ready_o = chain_ready[0];

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    evc_trig_cell #(
      .USE_X   (CELL_USE_X[g]),
      .LOAD_X2 (CELL_LOAD_X2[g]),
      .SEED_EN (CELL_SEED_EN[g]),
      .SEED    (POLY_A9),
      .ADDEND  (CELL_ADD[g])
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[g]),
      .in_ready_o  (chain_ready[g]),
      .in_data_i   (chain_data[g]),
      .out_valid_o (chain_valid[g+1]),
      .out_ready_i (chain_ready[g+1]),
      .out_data_o  (chain_data[g+1])
    );
  end

  evc_basis u_basis (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[NCELL]),
    .in_ready_o  (chain_ready[NCELL]),
    .in_data_i   (chain_data[NCELL]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// File: hdl/evc_checker.sv
// Port level checks of the Euler XYZ view matrix core and their binding.
module evc_checker
  import evc_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input evc_out_t out_o
);

  logic       in_acc, out_acc;
  logic [5:0] pending_q;

  assign in_acc = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 6'd1;
    end else if (!in_acc && out_acc) begin
      pending_q <= pending_q - 6'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("Output transaction dropped or changed while stalled.");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 6'd0)
    else $error("Output transaction without a pending input transaction.");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 6'(EVC_DEPTH))
    else $error("More transactions in flight than pipeline stages.");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.ux <= 16'sd16384) && (out_o.ux >= -16'sd16384)
                 && (out_o.wz <= 16'sd16384) && (out_o.wz >= -16'sd16384))
    else $error("Rotation entry outside the unit range.");

endmodule

bind euler_xyz_view_matrix_core evc_checker u_evc_checker (.*);
